// ===== design/pcc_pkg.sv =====
// pcc_pkg: shared constants, register index codes and types for the palette color classifier.
// No dependencies.
package pcc_pkg;

    localparam int PALETTE_SIZE    = 3;
    localparam int NUM_COLORS      = 3;
    localparam int COUNT_WIDTH     = 22;
    localparam int CHAN_WIDTH      = 8;
    localparam int COLOR_WIDTH     = 3 * CHAN_WIDTH;
    localparam int DIST_WIDTH      = 10;
    localparam int DIV_WIDTH       = 8;
    localparam int USE_WIDTH       = 2;
    localparam int CLS_WIDTH       = 2;
    localparam int PROD_WIDTH      = COUNT_WIDTH + DIV_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = COLOR_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLOR_ZERO  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLOR_ONE   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLOR_TWO   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLORS_USED = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHARE_DIV   = 3'd5;

    localparam logic [DIST_WIDTH-1:0] THRESHOLD_RESET = 10'd220;
    localparam logic [DIV_WIDTH-1:0]  SHARE_DIV_RESET = 8'd20;

    localparam logic [CLS_WIDTH-1:0] CLS_NONE = 2'd0;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [NUM_COLORS-1:0][COUNT_WIDTH-1:0] t_count_arr;
    typedef logic [NUM_COLORS-1:0][COLOR_WIDTH-1:0] t_palette;

    localparam t_count COUNT_MAX = '1;

    typedef struct packed {
        logic [CLS_WIDTH-1:0] cls;
        logic                 last;
    } t_tag;

endpackage

// ===== design/palette_color_classifier_top.sv =====
// palette_color_classifier_top: config registers, four-stage request pipeline and result register.
// Depends on pcc_pkg, pcc_classify, pcc_frame_stats, pcc_share_test.
// The block takes one pixel request per cycle while the output is not stalled and returns one
// result per request. The pipeline has four register stages: the input register, the class
// and frame counter stage, the product stage (match count times share divisor) and the result
// register; a stall on the output backs up only as far as the first empty stage, so bubbles
// are absorbed. The frame verdict uses the counts including the last pixel, and the counters
// clear as that pixel enters the class stage. Write configuration only while no request is in
// flight.
module palette_color_classifier_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pcc_pkg::CHAN_WIDTH-1:0]      i_blue,
    input  logic [pcc_pkg::CHAN_WIDTH-1:0]      i_green,
    input  logic [pcc_pkg::CHAN_WIDTH-1:0]      i_red,
    input  logic                                i_last_in_frame,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pcc_pkg::CLS_WIDTH-1:0]       o_color_class,
    output logic                                o_in_mask,
    output logic                                o_frame_end,
    output logic                                o_region_found
);

    pcc_pkg::t_palette                r_palette;
    logic [pcc_pkg::USE_WIDTH-1:0]    r_colors_in_use;
    logic [pcc_pkg::DIST_WIDTH-1:0]   r_threshold;
    logic [pcc_pkg::DIV_WIDTH-1:0]    r_share_div;

    logic                             r_v0, r_v1, r_v2, r_v3;
    logic                             en0, en1, en2, en3;
    logic [pcc_pkg::CHAN_WIDTH-1:0]   r_blue, r_green, r_red;
    logic                             r_last0;
    pcc_pkg::t_tag                    r_tag1, r_tag2;
    logic [pcc_pkg::CLS_WIDTH-1:0]    cls;
    logic [pcc_pkg::CLS_WIDTH-1:0]    r_cls3;
    logic                             r_last3, r_found3;
    logic                             found;
    pcc_pkg::t_count_arr              snap_cnt;
    pcc_pkg::t_count                  snap_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette       <= '0;
            r_colors_in_use <= '0;
            r_threshold     <= pcc_pkg::THRESHOLD_RESET;
            r_share_div     <= pcc_pkg::SHARE_DIV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcc_pkg::REG_COLOR_ZERO:  r_palette[0]    <= i_cfg_data;
                pcc_pkg::REG_COLOR_ONE:   r_palette[1]    <= i_cfg_data;
                pcc_pkg::REG_COLOR_TWO:   r_palette[2]    <= i_cfg_data;
                pcc_pkg::REG_COLORS_USED: r_colors_in_use <= i_cfg_data[pcc_pkg::USE_WIDTH-1:0];
                pcc_pkg::REG_THRESHOLD:   r_threshold     <= i_cfg_data[pcc_pkg::DIST_WIDTH-1:0];
                pcc_pkg::REG_SHARE_DIV:   r_share_div     <= i_cfg_data[pcc_pkg::DIV_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;
    assign o_in_ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_in_valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
            r_last0 <= i_last_in_frame;
        end
        if (en1) begin
            r_tag1.cls  <= cls;
            r_tag1.last <= r_last0;
        end
        if (en2) begin
            r_tag2 <= r_tag1;
        end
        if (en3) begin
            r_cls3   <= r_tag2.cls;
            r_last3  <= r_tag2.last;
            r_found3 <= found && r_tag2.last;
        end
    end

    pcc_classify u_classify (
        .i_blue          (r_blue),
        .i_green         (r_green),
        .i_red           (r_red),
        .i_palette       (r_palette),
        .i_colors_in_use (r_colors_in_use),
        .i_threshold     (r_threshold),
        .o_cls           (cls)
    );

    pcc_frame_stats u_frame_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (r_v0 && en1),
        .i_cls      (cls),
        .i_last     (r_last0),
        .o_snap_cnt (snap_cnt),
        .o_snap_pix (snap_pix)
    );

    pcc_share_test u_share_test (
        .i_clk      (i_clk),
        .i_en       (en2),
        .i_snap_cnt (snap_cnt),
        .i_snap_pix (snap_pix),
        .i_div      (r_share_div),
        .o_found    (found)
    );

    assign o_out_valid    = r_v3;
    assign o_color_class  = r_cls3;
    assign o_in_mask      = (r_cls3 != pcc_pkg::CLS_NONE);
    assign o_frame_end    = r_last3;
    assign o_region_found = r_found3;

    a_found_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_end |-> !o_region_found)
        else $error("region_found set on a pixel that does not end the frame");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register is empty");

    a_result_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3) |=> o_out_valid)
        else $error("product stage request lost on its way to the result register");

endmodule

// ===== design/pcc_classify.sv =====
// pcc_classify: L1 distance of one pixel to each palette color, first match wins.
// Depends on pcc_pkg.
module pcc_classify (
    input  logic [pcc_pkg::CHAN_WIDTH-1:0] i_blue,
    input  logic [pcc_pkg::CHAN_WIDTH-1:0] i_green,
    input  logic [pcc_pkg::CHAN_WIDTH-1:0] i_red,
    input  pcc_pkg::t_palette              i_palette,
    input  logic [pcc_pkg::USE_WIDTH-1:0]  i_colors_in_use,
    input  logic [pcc_pkg::DIST_WIDTH-1:0] i_threshold,
    output logic [pcc_pkg::CLS_WIDTH-1:0]  o_cls
);

    logic [pcc_pkg::NUM_COLORS-1:0] hit;

    function automatic logic [pcc_pkg::CHAN_WIDTH-1:0] abs_diff(
        input logic [pcc_pkg::CHAN_WIDTH-1:0] a,
        input logic [pcc_pkg::CHAN_WIDTH-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        logic [pcc_pkg::DIST_WIDTH-1:0] l1_sum;
        for (int i = 0; i < pcc_pkg::NUM_COLORS; i++) begin
            l1_sum = pcc_pkg::DIST_WIDTH'(abs_diff(i_blue,  i_palette[i][7:0]))
                   + pcc_pkg::DIST_WIDTH'(abs_diff(i_green, i_palette[i][15:8]))
                   + pcc_pkg::DIST_WIDTH'(abs_diff(i_red,   i_palette[i][23:16]));
            hit[i] = (l1_sum <= i_threshold)
                  && (i < int'(i_colors_in_use))
                  && (i < pcc_pkg::PALETTE_SIZE);
        end
    end

    always_comb begin
        o_cls = pcc_pkg::CLS_NONE;
        for (int i = pcc_pkg::NUM_COLORS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_cls = pcc_pkg::CLS_WIDTH'(i + 1);
            end
        end
    end

endmodule

// ===== design/pcc_frame_stats.sv =====
// pcc_frame_stats: saturating per-color match counters and pixel counter, snapshot of the
// updated counts taken on each pixel, counters cleared on the last pixel. Depends on pcc_pkg.
module pcc_frame_stats (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [pcc_pkg::CLS_WIDTH-1:0] i_cls,
    input  logic                          i_last,
    output pcc_pkg::t_count_arr           o_snap_cnt,
    output pcc_pkg::t_count               o_snap_pix
);

    pcc_pkg::t_count_arr r_match_cnt;
    pcc_pkg::t_count_arr n_match_cnt;
    pcc_pkg::t_count     r_pix_cnt;
    pcc_pkg::t_count     n_pix_cnt;
    pcc_pkg::t_count_arr r_snap_cnt;
    pcc_pkg::t_count     r_snap_pix;

    always_comb begin
        for (int i = 0; i < pcc_pkg::NUM_COLORS; i++) begin
            if (i_cls == pcc_pkg::CLS_WIDTH'(i + 1) && r_match_cnt[i] != pcc_pkg::COUNT_MAX) begin
                n_match_cnt[i] = r_match_cnt[i] + 1'b1;
            end else begin
                n_match_cnt[i] = r_match_cnt[i];
            end
        end
        n_pix_cnt = (r_pix_cnt == pcc_pkg::COUNT_MAX) ? r_pix_cnt : r_pix_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_cnt <= '0;
            r_pix_cnt   <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_match_cnt <= '0;
                r_pix_cnt   <= '0;
            end else begin
                r_match_cnt <= n_match_cnt;
                r_pix_cnt   <= n_pix_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_snap_cnt <= n_match_cnt;
            r_snap_pix <= n_pix_cnt;
        end
    end

    assign o_snap_cnt = r_snap_cnt;
    assign o_snap_pix = r_snap_pix;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> (r_pix_cnt == '0 && r_match_cnt == '0))
        else $error("counters not cleared after last pixel");

    a_pix_covers_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix_cnt >= r_match_cnt[0]) && (r_pix_cnt >= r_match_cnt[1])
        && (r_pix_cnt >= r_match_cnt[2]))
        else $error("match count exceeds pixel count");

    a_pix_increments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_last && r_pix_cnt != pcc_pkg::COUNT_MAX)
        |=> (r_pix_cnt == $past(r_pix_cnt) + 1'b1))
        else $error("pixel counter did not advance");

endmodule

// ===== design/pcc_share_test.sv =====
// pcc_share_test: scales the frame's match counts by the share divisor (registered),
// then compares each against the pixel count. Depends on pcc_pkg.
module pcc_share_test (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  pcc_pkg::t_count_arr           i_snap_cnt,
    input  pcc_pkg::t_count               i_snap_pix,
    input  logic [pcc_pkg::DIV_WIDTH-1:0] i_div,
    output logic                          o_found
);

    logic [pcc_pkg::NUM_COLORS-1:0][pcc_pkg::PROD_WIDTH-1:0] r_prod;
    logic [pcc_pkg::PROD_WIDTH-1:0]                          r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < pcc_pkg::NUM_COLORS; i++) begin
                r_prod[i] <= pcc_pkg::PROD_WIDTH'(i_snap_cnt[i])
                           * pcc_pkg::PROD_WIDTH'(i_div);
            end
            r_pix <= pcc_pkg::PROD_WIDTH'(i_snap_pix);
        end
    end

    always_comb begin
        o_found = 1'b0;
        for (int i = 0; i < pcc_pkg::NUM_COLORS; i++) begin
            if (r_prod[i] >= r_pix) begin
                o_found = 1'b1;
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for palette_color_classifier_top.
// Depends on pcc_pkg and the palette_color_classifier_top RTL; a pixel predictor or
// a pinned value checks every result, in order, in a directed plan and random frames.
module tb_top;

    localparam logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_SIX   = 3'd6;
    localparam logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_SEVEN = 3'd7;
    localparam logic [pcc_pkg::CLS_WIDTH-1:0] CLS_COLOR_ZERO = 2'd1;
    localparam logic [pcc_pkg::CLS_WIDTH-1:0] CLS_COLOR_ONE  = 2'd2;
    localparam logic [pcc_pkg::CLS_WIDTH-1:0] CLS_COLOR_TWO  = 2'd3;
    localparam int DRAIN_SLACK     = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int NUM_PHASES      = 8;
    localparam int PIXELS_PER_PHASE = 125;

    typedef struct packed {
        logic [pcc_pkg::CLS_WIDTH-1:0] cls;
        logic                          mask;
        logic                          fend;
        logic                          found;
    } t_pix_result;

    typedef enum logic {ROW_WRITE, ROW_PIXEL} t_row_kind;

    typedef struct {
        t_row_kind                           kind;
        logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] idx;
        logic [pcc_pkg::CFG_DATA_WIDTH-1:0]  data;
        logic [pcc_pkg::CHAN_WIDTH-1:0]      b;
        logic [pcc_pkg::CHAN_WIDTH-1:0]      g;
        logic [pcc_pkg::CHAN_WIDTH-1:0]      r;
        logic                                last;
        logic                                pin;
        t_pix_result                         res;
    } t_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [pcc_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic [pcc_pkg::CHAN_WIDTH-1:0]      i_blue;
    logic [pcc_pkg::CHAN_WIDTH-1:0]      i_green;
    logic [pcc_pkg::CHAN_WIDTH-1:0]      i_red;
    logic                                i_last_in_frame;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic [pcc_pkg::CLS_WIDTH-1:0]       o_color_class;
    logic                                o_in_mask;
    logic                                o_frame_end;
    logic                                o_region_found;

    // predictor state
    logic [pcc_pkg::COLOR_WIDTH-1:0] pal [pcc_pkg::NUM_COLORS];
    logic [pcc_pkg::USE_WIDTH-1:0]   used;
    logic [pcc_pkg::DIST_WIDTH-1:0]  match_thr;
    logic [pcc_pkg::DIV_WIDTH-1:0]   share_div;
    pcc_pkg::t_count                 hits [pcc_pkg::NUM_COLORS];
    pcc_pkg::t_count                 pixels;

    t_pix_result expected_results [$];
    t_pix_result pin_res;
    t_pix_result got_res;
    t_pix_result want_res;
    logic        pin_valid;
    t_row        plan [$];
    int          err_count = 0;
    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    bit          hold_off_req = 1'b0;

    palette_color_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_blue          (i_blue),
        .i_green         (i_green),
        .i_red           (i_red),
        .i_last_in_frame (i_last_in_frame),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_color_class   (o_color_class),
        .o_in_mask       (o_in_mask),
        .o_frame_end     (o_frame_end),
        .o_region_found  (o_region_found)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int abs_gap(logic [pcc_pkg::CHAN_WIDTH-1:0] a,
                                   logic [pcc_pkg::CHAN_WIDTH-1:0] c);
        return (a >= c) ? int'(a) - int'(c) : int'(c) - int'(a);
    endfunction

    function automatic t_pix_result classify_pixel(logic [pcc_pkg::CHAN_WIDTH-1:0] b,
                                                   logic [pcc_pkg::CHAN_WIDTH-1:0] g,
                                                   logic [pcc_pkg::CHAN_WIDTH-1:0] r,
                                                   logic last);
        t_pix_result       res;
        int                lim;
        int                l1_sum;
        longint unsigned   prod;
        res = '0;
        lim = int'(used);
        if (lim > pcc_pkg::PALETTE_SIZE) lim = pcc_pkg::PALETTE_SIZE;
        if (lim > pcc_pkg::NUM_COLORS) lim = pcc_pkg::NUM_COLORS;
        for (int i = 0; i < lim && res.cls == pcc_pkg::CLS_NONE; i++) begin
            l1_sum = abs_gap(b, pal[i][7:0]) + abs_gap(g, pal[i][15:8])
                   + abs_gap(r, pal[i][23:16]);
            if (l1_sum <= int'(match_thr)) begin
                res.cls = pcc_pkg::CLS_WIDTH'(i + 1);
                if (hits[i] != pcc_pkg::COUNT_MAX) hits[i] = hits[i] + 1'b1;
            end
        end
        if (pixels != pcc_pkg::COUNT_MAX) pixels = pixels + 1'b1;
        res.mask = (res.cls != pcc_pkg::CLS_NONE);
        res.fend = last;
        if (last) begin
            for (int i = 0; i < pcc_pkg::NUM_COLORS; i++) begin
                prod = 64'(hits[i]);
                prod = prod * 64'(share_div);
                if (prod >= 64'(pixels)) res.found = 1'b1;
                hits[i] = '0;
            end
            pixels = '0;
        end
        return res;
    endfunction

    function automatic void update_regs(logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                        logic [pcc_pkg::CFG_DATA_WIDTH-1:0] data);
        case (idx)
            pcc_pkg::REG_COLOR_ZERO:  pal[0] = data[pcc_pkg::COLOR_WIDTH-1:0];
            pcc_pkg::REG_COLOR_ONE:   pal[1] = data[pcc_pkg::COLOR_WIDTH-1:0];
            pcc_pkg::REG_COLOR_TWO:   pal[2] = data[pcc_pkg::COLOR_WIDTH-1:0];
            pcc_pkg::REG_COLORS_USED: used = data[pcc_pkg::USE_WIDTH-1:0];
            pcc_pkg::REG_THRESHOLD:   match_thr = data[pcc_pkg::DIST_WIDTH-1:0];
            pcc_pkg::REG_SHARE_DIV:   share_div = data[pcc_pkg::DIV_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    task automatic add_write(logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             logic [pcc_pkg::CFG_DATA_WIDTH-1:0] data);
        t_row row;
        row = '{kind: ROW_WRITE, idx: idx, data: data, default: '0};
        plan = {plan, row};
    endtask

    task automatic add_pixel(logic [pcc_pkg::CHAN_WIDTH-1:0] b,
                             logic [pcc_pkg::CHAN_WIDTH-1:0] g,
                             logic [pcc_pkg::CHAN_WIDTH-1:0] r, logic last, logic pin,
                             t_pix_result res);
        t_row row;
        row = '{kind: ROW_PIXEL, b: b, g: g, r: r, last: last, pin: pin, res: res,
                default: '0};
        plan = {plan, row};
    endtask

    task automatic write_reg(logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             logic [pcc_pkg::CFG_DATA_WIDTH-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        update_regs(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [pcc_pkg::CHAN_WIDTH-1:0] b,
                              logic [pcc_pkg::CHAN_WIDTH-1:0] g,
                              logic [pcc_pkg::CHAN_WIDTH-1:0] r, logic last, logic pin,
                              t_pix_result res);
        int gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_blue          <= b;
        i_green         <= g;
        i_red           <= r;
        i_last_in_frame <= last;
        pin_valid       <= pin;
        pin_res         <= res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic check_field(string fld, int want, int got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, fld, want, got);
        end
    endtask

    // request side: predict at acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            got_res = classify_pixel(i_blue, i_green, i_red, i_last_in_frame);
            expected_results = {expected_results, (pin_valid ? pin_res : got_res)};
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result, expected none actual class %0d",
                         $time, o_color_class);
            end else begin
                want_res = expected_results.pop_front();
                check_field("color_class", int'(want_res.cls), int'(o_color_class));
                check_field("in_mask", int'(want_res.mask), int'(o_in_mask));
                check_field("frame_end", int'(want_res.fend), int'(o_frame_end));
                check_field("region_found", int'(want_res.found), int'(o_region_found));
            end
        end
    end

    // receiver
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = recv_idle ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // sender and sequencing
    initial begin
        int                              sent;
        int                              flen;
        int                              used_pick;
        int                              thr_pick;
        int                              div_pick;
        logic [pcc_pkg::CHAN_WIDTH-1:0]  mask_bits;
        logic [pcc_pkg::COLOR_WIDTH-1:0] base;
        logic [pcc_pkg::CHAN_WIDTH-1:0]  pb, pg, pr;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_blue          <= '0;
        i_green         <= '0;
        i_red           <= '0;
        i_last_in_frame <= 1'b0;
        pin_valid       <= 1'b0;
        pin_res         <= '0;
        for (int i = 0; i < pcc_pkg::NUM_COLORS; i++) begin
            pal[i]  = '0;
            hits[i] = '0;
        end
        used      = '0;
        match_thr = pcc_pkg::THRESHOLD_RESET;
        share_div = pcc_pkg::SHARE_DIV_RESET;
        pixels    = '0;

        // reset values: no colors in use
        add_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{pcc_pkg::CLS_NONE, 1'b0, 1'b0, 1'b0});
        add_pixel(8'hff, 8'hff, 8'hff, 1'b1, 1'b1, '{pcc_pkg::CLS_NONE, 1'b0, 1'b1, 1'b0});
        add_write(pcc_pkg::REG_COLOR_ZERO, 24'h000000);
        add_write(pcc_pkg::REG_COLOR_ONE, 24'hffffff);
        add_write(pcc_pkg::REG_COLOR_TWO, 24'h808080);
        add_write(pcc_pkg::REG_COLORS_USED, 24'd3);
        add_write(pcc_pkg::REG_THRESHOLD, 24'd0);
        add_write(pcc_pkg::REG_SHARE_DIV, 24'd1);
        add_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
        add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, '0);
        add_pixel(8'h80, 8'h80, 8'h80, 1'b0, 1'b0, '0);
        add_pixel(8'h01, 8'h00, 8'h00, 1'b1, 1'b1, '{pcc_pkg::CLS_NONE, 1'b0, 1'b1, 1'b0});
        // threshold beyond any distance, divisor zero
        add_write(pcc_pkg::REG_THRESHOLD, 24'hffffff);
        add_write(pcc_pkg::REG_SHARE_DIV, 24'd0);
        add_pixel(8'h12, 8'h34, 8'h56, 1'b1, 1'b1, '{CLS_COLOR_ZERO, 1'b1, 1'b1, 1'b0});
        add_write(pcc_pkg::REG_SHARE_DIV, 24'd255);
        add_write(pcc_pkg::REG_THRESHOLD, 24'd765);
        add_write(pcc_pkg::REG_COLORS_USED, 24'd2);
        add_pixel(8'h80, 8'h80, 8'h80, 1'b0, 1'b0, '0);
        add_pixel(8'hff, 8'hff, 8'hff, 1'b1, 1'b1, '{CLS_COLOR_ZERO, 1'b1, 1'b1, 1'b1});
        // threshold edge
        add_write(pcc_pkg::REG_COLORS_USED, 24'd1);
        add_write(pcc_pkg::REG_THRESHOLD, 24'd10);
        add_write(pcc_pkg::REG_COLOR_ZERO, 24'h102030);
        add_pixel(8'h35, 8'h20, 8'h10, 1'b0, 1'b0, '0);
        add_pixel(8'h30, 8'h2a, 8'h10, 1'b0, 1'b0, '0);
        add_pixel(8'h30, 8'h20, 8'h1b, 1'b0, 1'b0, '0);
        add_pixel(8'hff, 8'hff, 8'hff, 1'b1, 1'b1, '{pcc_pkg::CLS_NONE, 1'b0, 1'b1, 1'b1});
        // unknown indexes are ignored
        add_write(REG_UNUSED_SIX, 24'hffffff);
        add_write(REG_UNUSED_SEVEN, 24'hffffff);
        add_write(pcc_pkg::REG_COLOR_ZERO, 24'hffffff);
        add_write(pcc_pkg::REG_COLOR_ONE, 24'h000000);
        add_write(pcc_pkg::REG_COLOR_TWO, 24'h102030);
        add_write(pcc_pkg::REG_COLORS_USED, 24'hffffff);
        add_write(pcc_pkg::REG_THRESHOLD, 24'd0);
        add_write(pcc_pkg::REG_SHARE_DIV, 24'd2);
        add_pixel(8'h30, 8'h20, 8'h10, 1'b0, 1'b0, '0);
        add_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
        add_pixel(8'h30, 8'h20, 8'h10, 1'b1, 1'b1, '{CLS_COLOR_TWO, 1'b1, 1'b1, 1'b1});
        add_write(pcc_pkg::REG_COLORS_USED, 24'hfffffc);
        add_pixel(8'h30, 8'h20, 8'h10, 1'b1, 1'b1, '{pcc_pkg::CLS_NONE, 1'b0, 1'b1, 1'b0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_WRITE) begin
                drain();
                write_reg(plan[n].idx, plan[n].data);
            end else begin
                send_pixel(plan[n].b, plan[n].g, plan[n].r, plan[n].last,
                           plan[n].pin, plan[n].res);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            for (int c = 0; c < pcc_pkg::NUM_COLORS; c++)
                write_reg(pcc_pkg::CFG_INDEX_WIDTH'(pcc_pkg::REG_COLOR_ZERO + c),
                          pcc_pkg::CFG_DATA_WIDTH'($urandom));
            used_pick = $urandom_range(0, 5);
            if (used_pick > 3) used_pick = 3;
            case ($urandom_range(0, 4))
                0:       thr_pick = 0;
                1:       thr_pick = 765;
                2:       thr_pick = 1023;
                default: thr_pick = $urandom_range(0, 200);
            endcase
            case ($urandom_range(0, 4))
                0:       div_pick = 0;
                1:       div_pick = 1;
                2:       div_pick = 255;
                default: div_pick = $urandom_range(2, 40);
            endcase
            if (ph == 0) begin
                used_pick = 3;
                thr_pick  = 0;
                div_pick  = 1;
            end else if (ph == 1) begin
                thr_pick = 1023;
                div_pick = 0;
            end
            write_reg(pcc_pkg::REG_COLORS_USED,
                      (pcc_pkg::CFG_DATA_WIDTH'($urandom) & 24'hfffffc)
                      | pcc_pkg::CFG_DATA_WIDTH'(used_pick));
            write_reg(pcc_pkg::REG_THRESHOLD,
                      (pcc_pkg::CFG_DATA_WIDTH'($urandom) & 24'hfffc00)
                      | pcc_pkg::CFG_DATA_WIDTH'(thr_pick));
            write_reg(pcc_pkg::REG_SHARE_DIV,
                      (pcc_pkg::CFG_DATA_WIDTH'($urandom) & 24'hffff00)
                      | pcc_pkg::CFG_DATA_WIDTH'(div_pick));
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_UNUSED_SIX : REG_UNUSED_SEVEN,
                          pcc_pkg::CFG_DATA_WIDTH'($urandom));

            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (ph == 2) begin
                send_idle    = 1'b0;
                hold_off_req = 1'b1;
            end

            sent = 0;
            while (sent < PIXELS_PER_PHASE) begin
                flen = $urandom_range(1, 30);
                for (int k = 0; k < flen; k++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        base = pal[$urandom_range(0, pcc_pkg::NUM_COLORS - 1)];
                        case ($urandom_range(0, 2))
                            0:       mask_bits = 8'h00;
                            1:       mask_bits = 8'h07;
                            default: mask_bits = 8'h3f;
                        endcase
                        pb = base[7:0]   ^ (pcc_pkg::CHAN_WIDTH'($urandom) & mask_bits);
                        pg = base[15:8]  ^ (pcc_pkg::CHAN_WIDTH'($urandom) & mask_bits);
                        pr = base[23:16] ^ (pcc_pkg::CHAN_WIDTH'($urandom) & mask_bits);
                    end else begin
                        pb = pcc_pkg::CHAN_WIDTH'($urandom);
                        pg = pcc_pkg::CHAN_WIDTH'($urandom);
                        pr = pcc_pkg::CHAN_WIDTH'($urandom);
                    end
                    send_pixel(pb, pg, pr, k == flen - 1, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pcc_pkg.sv
design/pcc_classify.sv
design/pcc_frame_stats.sv
design/pcc_share_test.sv
design/palette_color_classifier_top.sv
tb/sv/tb_top.sv
